// ----- hw/rtl/dpo_pkg.sv -----
`timescale 1ns / 1ps

package dpo_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SHARED_W = 22;

  // day number from 0001-01-01 for any 14-bit year fits in 23 bits
  localparam int DAYNUM_W = 23;
  // day of year offset, 0..365
  localparam int DOY_W    = 9;

  localparam int NUM_DATES    = 4;
  localparam int MAX_YEAR_DEF = 9999;

  // year / 100 as (year * 5243) >> 19, exact for all 14-bit years
  localparam int RECIP_W      = 13;
  localparam int RECIP_SH     = 19;
  localparam int PROD_W       = YEAR_W + RECIP_W;
  localparam int QUO_W        = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

  localparam logic [DAYNUM_W-1:0] DAYS_PER_YEAR = DAYNUM_W'(365);
  localparam logic [YEAR_W-1:0]   CENTURY       = YEAR_W'(100);

  // month codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [SHARED_W:0] SHARED_MAX = {1'b0, {SHARED_W{1'b1}}};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic                bad;
    logic [DAYNUM_W-1:0] num;
  } conv_t;

  // length of a month, month code 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic is_leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      4'd2:                    len = is_leap ? DAY_W'(29) : DAY_W'(28);
      default:                 len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // days in the year before the first of the month, month code 1..12
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd1:    n = DOY_W'(0);
      4'd2:    n = DOY_W'(31);
      4'd3:    n = DOY_W'(59);
      4'd4:    n = DOY_W'(90);
      4'd5:    n = DOY_W'(120);
      4'd6:    n = DOY_W'(151);
      4'd7:    n = DOY_W'(181);
      4'd8:    n = DOY_W'(212);
      4'd9:    n = DOY_W'(243);
      4'd10:   n = DOY_W'(273);
      4'd11:   n = DOY_W'(304);
      4'd12:   n = DOY_W'(334);
      default: n = DOY_W'(0);
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/date_period_overlap_days.sv -----
`timescale 1ns / 1ps

// Counts the calendar days shared by two Gregorian date periods.
// Input: an item is the four dates (first start, first end, second start,
// second end), each as year, month and day. It is taken at a rising edge
// with start high; busy is always low, so an item may be given every cycle.
// Output: done is high for one cycle with shared_days and invalid_date.
// The result of an item is registered through six register stages in order:
// input, reciprocal product, leap/validity, day number, min/max, result.
// Throughput is one item per cycle.
// Years are clamped to 1..MAX_YEAR; a bad month or day sets invalid_date
// and gives a count of zero; disjoint or reversed periods give zero.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst, synchronous) drops all items in flight; no done follows.

module date_period_overlap_days #(
  parameter int MAX_YEAR = dpo_pkg::MAX_YEAR_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dpo_pkg::YEAR_W-1:0]    first_start_year,
  input  logic [dpo_pkg::MONTH_W-1:0]   first_start_month,
  input  logic [dpo_pkg::DAY_W-1:0]     first_start_day,
  input  logic [dpo_pkg::YEAR_W-1:0]    first_end_year,
  input  logic [dpo_pkg::MONTH_W-1:0]   first_end_month,
  input  logic [dpo_pkg::DAY_W-1:0]     first_end_day,
  input  logic [dpo_pkg::YEAR_W-1:0]    second_start_year,
  input  logic [dpo_pkg::MONTH_W-1:0]   second_start_month,
  input  logic [dpo_pkg::DAY_W-1:0]     second_start_day,
  input  logic [dpo_pkg::YEAR_W-1:0]    second_end_year,
  input  logic [dpo_pkg::MONTH_W-1:0]   second_end_month,
  input  logic [dpo_pkg::DAY_W-1:0]     second_end_day,
  output logic                          done,
  output logic [dpo_pkg::SHARED_W-1:0]  shared_days,
  output logic                          invalid_date
);

  dpo_pkg::date_t [dpo_pkg::NUM_DATES-1:0] dates;
  dpo_pkg::conv_t [dpo_pkg::NUM_DATES-1:0] conv;
  logic                                    accept;
  logic [3:0]                              valid;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      dates[0] <= '{first_start_year, first_start_month, first_start_day};
      dates[1] <= '{first_end_year, first_end_month, first_end_day};
      dates[2] <= '{second_start_year, second_start_month, second_start_day};
      dates[3] <= '{second_end_year, second_end_month, second_end_day};
    end
  end

  // valid marks alongside the date conversion stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], accept};
    end
  end

  // one day number converter per date
  for (genvar i = 0; i < dpo_pkg::NUM_DATES; i++) begin : g_conv
    dpo_date_conv #(
      .MAX_YEAR (MAX_YEAR)
    ) u_conv (
      .clk  (clk),
      .date (dates[i]),
      .conv (conv[i])
    );
  end

  dpo_overlap u_overlap (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (valid[3]),
    .conv         (conv),
    .done         (done),
    .shared_days  (shared_days),
    .invalid_date (invalid_date)
  );

  // every accepted item gives exactly one result
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted item produced no result");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 6))
    else $error("result without an accepted item");

endmodule

// ----- hw/rtl/dpo_date_conv.sv -----
`timescale 1ns / 1ps

module dpo_date_conv #(
  parameter int MAX_YEAR = dpo_pkg::MAX_YEAR_DEF
) (
  input  logic           clk,
  input  dpo_pkg::date_t date,
  output dpo_pkg::conv_t conv
);

  localparam int YW = dpo_pkg::YEAR_W;
  localparam int NW = dpo_pkg::DAYNUM_W;
  localparam int QW = dpo_pkg::QUO_W;
  localparam int PW = dpo_pkg::PROD_W;
  localparam logic [YW:0] MaxYearWide = (YW + 1)'(MAX_YEAR);

  logic [YW-1:0]             year_cl;
  logic [YW-1:0]             year1;
  logic [dpo_pkg::MONTH_W-1:0] month1;
  logic [dpo_pkg::DAY_W-1:0]   day1;
  logic [PW-1:0]             prod_y1;
  logic [PW-1:0]             prod_p1;

  logic [YW-1:0]             p;
  logic [QW-1:0]             q_y;
  logic [QW-1:0]             q_p;
  logic                      is_leap;
  logic                      ok;
  logic [NW-1:0]             base_next;
  logic [dpo_pkg::DOY_W-1:0] doy_next;

  logic                      ok2;
  logic [NW-1:0]             base2;
  logic [dpo_pkg::DOY_W-1:0] doy2;

  // clamp the year into 1..MAX_YEAR
  always_comb begin
    if (date.year == '0) begin
      year_cl = YW'(1);
    end else if ({1'b0, date.year} > MaxYearWide) begin
      year_cl = MaxYearWide[YW-1:0];
    end else begin
      year_cl = date.year;
    end
  end

  // stage 1: reciprocal products for year / 100 and (year - 1) / 100
  always_ff @(posedge clk) begin
    year1   <= year_cl;
    month1  <= date.month;
    day1    <= date.day;
    prod_y1 <= PW'(year_cl) * PW'(dpo_pkg::RECIP_100);
    prod_p1 <= PW'(year_cl - YW'(1)) * PW'(dpo_pkg::RECIP_100);
  end

  // leap rule, validity and the year part of the day number
  always_comb begin
    p       = year1 - YW'(1);
    q_y     = prod_y1[PW-1:dpo_pkg::RECIP_SH];
    q_p     = prod_p1[PW-1:dpo_pkg::RECIP_SH];
    // divisible by 4, and either not by 100 or by 400
    is_leap = (year1[1:0] == 2'b00) &&
              ((year1 != YW'(q_y) * dpo_pkg::CENTURY) || (q_y[1:0] == 2'b00));
    ok      = (month1 >= dpo_pkg::MONTH_JAN) && (month1 <= dpo_pkg::MONTH_DEC) &&
              (day1 != '0) && (day1 <= dpo_pkg::month_len(month1, is_leap));
    base_next = NW'(p) * dpo_pkg::DAYS_PER_YEAR + NW'(p >> 2) - NW'(q_p) + NW'(q_p >> 2);
    doy_next  = dpo_pkg::days_before(month1) + dpo_pkg::DOY_W'(day1) - dpo_pkg::DOY_W'(1);
    if (is_leap && (month1 > dpo_pkg::MONTH_FEB)) begin
      doy_next = doy_next + dpo_pkg::DOY_W'(1);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    ok2   <= ok;
    base2 <= base_next;
    doy2  <= doy_next;
  end

  // stage 3: full day number, zero for a bad date
  always_ff @(posedge clk) begin
    conv.bad <= !ok2;
    conv.num <= ok2 ? base2 + NW'(doy2) : '0;
  end

endmodule

// ----- hw/rtl/dpo_overlap.sv -----
`timescale 1ns / 1ps

module dpo_overlap (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  dpo_pkg::conv_t [dpo_pkg::NUM_DATES-1:0] conv,
  output logic                                   done,
  output logic [dpo_pkg::SHARED_W-1:0]           shared_days,
  output logic                                   invalid_date
);

  localparam int NW = dpo_pkg::DAYNUM_W;

  logic          valid4;
  logic          bad4;
  logic [NW-1:0] lo4;
  logic [NW-1:0] hi4;
  logic [NW:0]   span;

  // later start and earlier end
  always_ff @(posedge clk) begin
    bad4 <= conv[0].bad | conv[1].bad | conv[2].bad | conv[3].bad;
    lo4  <= (conv[0].num > conv[2].num) ? conv[0].num : conv[2].num;
    hi4  <= (conv[1].num < conv[3].num) ? conv[1].num : conv[3].num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid4 <= in_valid;
      done   <= valid4;
    end
  end

  // inclusive span length
  assign span = {1'b0, hi4} - {1'b0, lo4} + (NW + 1)'(1);

  // result register, count saturates at the port width
  always_ff @(posedge clk) begin
    invalid_date <= bad4;
    if (bad4 || (hi4 < lo4)) begin
      shared_days <= '0;
    end else if (span > (NW + 1)'(dpo_pkg::SHARED_MAX)) begin
      shared_days <= {dpo_pkg::SHARED_W{1'b1}};
    end else begin
      shared_days <= span[dpo_pkg::SHARED_W-1:0];
    end
  end

  // a bad date never reports a count
  assert property (@(posedge clk) disable iff (rst)
    done && invalid_date |-> shared_days == '0)
    else $error("nonzero count with invalid date");

  // a valid item in the min/max stage strobes the result next cycle
  assert property (@(posedge clk) disable iff (rst)
    valid4 |=> done)
    else $error("result strobe lost");

endmodule
